// ===== rtl/sim_pkg.sv =====
package sim_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int POS_W = 6;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DUP  = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [KEY_W-1:0] global_key;
		logic [VAL_W-1:0] local_value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] found_value;
	} rsp_t;

	typedef struct packed {
		logic cmp_en;
		logic ins_en;
	} cell_ctl_t;

endpackage

// ===== rtl/sim_cell.sv =====
module sim_cell #(
	parameter int INDEX = 0,
	parameter int CW = 7
) (
	input  logic                      clk,
	input  logic [CW-1:0]             count,
	input  sim_pkg::cell_ctl_t        ctl,
	input  logic [sim_pkg::KEY_W-1:0] search_key,
	input  logic [sim_pkg::KEY_W-1:0] new_key,
	input  logic [sim_pkg::VAL_W-1:0] new_value,
	input  logic [sim_pkg::KEY_W-1:0] prev_key,
	input  logic [sim_pkg::VAL_W-1:0] prev_value,
	input  logic                      prev_lt,
	output logic [sim_pkg::KEY_W-1:0] key,
	output logic [sim_pkg::VAL_W-1:0] value,
	output logic                      lt,
	output logic                      eq
);
	import sim_pkg::*;

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             lt_s2;
	logic             eq_s2;
	logic             occ;

	assign occ = IDX < count;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			lt_s2 <= occ && (key_q < search_key);
			eq_s2 <= occ && (key_q == search_key);
		end
		if (ctl.ins_en && !lt_s2) begin
			if (prev_lt) begin
				key_q   <= new_key;
				value_q <= new_value;
			end else begin
				key_q   <= prev_key;
				value_q <= prev_value;
			end
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign lt    = lt_s2;
	assign eq    = eq_s2;

endmodule

// ===== rtl/sim_sel.sv =====
module sim_sel #(
	parameter int DEPTH = 64,
	parameter int CW = 7
) (
	input  logic [DEPTH-1:0]                     lt,
	input  logic [DEPTH-1:0]                     eq,
	input  logic [DEPTH-1:0][sim_pkg::VAL_W-1:0] values,
	output logic [CW-1:0]                        pos,
	output logic                                 hit,
	output logic [sim_pkg::VAL_W-1:0]            hit_value
);
	import sim_pkg::*;

	logic [DEPTH-1:0] lt_prev;
	logic [DEPTH-1:0] first;

	assign lt_prev = {lt[DEPTH-2:0], 1'b1};
	assign first   = ~lt & lt_prev;
	assign hit     = |eq;

	always_comb begin
		pos       = '0;
		hit_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				pos = pos | CW'(i);
			end
			if (eq[i]) begin
				hit_value = hit_value | values[i];
			end
		end
		if (lt[DEPTH-1]) begin
			pos = CW'(DEPTH);
		end
	end

endmodule

// ===== rtl/sorted_id_map_insert_lookup.sv =====
// Sorted id map: a row of DEPTH cells kept in ascending key order.
// Request channel (req_valid / req_stall / req): an insert places the pair
// at its sorted place, shifting the cells above it up by one; a lookup
// returns the stored local id. Response channel (rsp_valid / rsp_stall /
// rsp) carries status, position and found value, one per request.
// A request accepted into the compare stage is compared against every cell
// there, and lt and eq are registered; then, in the commit stage, the cells
// shift and the response register loads, which raises rsp_valid.
// A new request is not taken while one sits in the compare stage, since the
// compare stage and the commit stage that follows it use the same row of cells.
// When the receiver stalls, the response holds in its register and the
// next request waits in the commit stage; req_stall rises until it drains.
// Reset clears the entry count and all valid flags; cell contents are left
// as they are and are never read before being written.
module sorted_id_map_insert_lookup #(
	parameter int DEPTH = sim_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sim_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sim_pkg::rsp_t rsp
);
	import sim_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic                          v_s1;
	logic                          v_s2;
	req_t                          req_s1;
	req_t                          req_s2;
	logic [CW-1:0]                 count_q;
	logic                          rsp_valid_q;
	rsp_t                          rsp_q;

	logic                          accept;
	logic                          commit;
	logic                          full;
	logic                          ins_en;
	cell_ctl_t                     ctl;
	logic [DEPTH-1:0]              lt;
	logic [DEPTH-1:0]              eq;
	logic [DEPTH-1:0][KEY_W-1:0]   keys;
	logic [DEPTH-1:0][VAL_W-1:0]   values;
	logic [CW-1:0]                 pos;
	logic                          hit;
	logic [VAL_W-1:0]              hit_value;
	rsp_t                          rsp_d;

	assign commit    = v_s2 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = v_s1 || (v_s2 && !commit);
	assign accept    = req_valid && !req_stall;
	assign full      = count_q >= DEPTH_C;
	assign ins_en    = commit && (req_s2.operation == OP_INSERT) && !full && !hit;
	assign ctl.cmp_en = v_s1;
	assign ctl.ins_en = ins_en;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			sim_cell #(.INDEX(i), .CW(CW)) u_cell (
				.clk        (clk),
				.count      (count_q),
				.ctl        (ctl),
				.search_key (req_s1.global_key),
				.new_key    (req_s2.global_key),
				.new_value  (req_s2.local_value),
				.prev_key   (req_s2.global_key),
				.prev_value (req_s2.local_value),
				.prev_lt    (1'b1),
				.key        (keys[i]),
				.value      (values[i]),
				.lt         (lt[i]),
				.eq         (eq[i])
			);
		end else begin : g_body
			sim_cell #(.INDEX(i), .CW(CW)) u_cell (
				.clk        (clk),
				.count      (count_q),
				.ctl        (ctl),
				.search_key (req_s1.global_key),
				.new_key    (req_s2.global_key),
				.new_value  (req_s2.local_value),
				.prev_key   (keys[i-1]),
				.prev_value (values[i-1]),
				.prev_lt    (lt[i-1]),
				.key        (keys[i]),
				.value      (values[i]),
				.lt         (lt[i]),
				.eq         (eq[i])
			);
		end
	end

	sim_sel #(.DEPTH(DEPTH), .CW(CW)) u_sel (
		.lt        (lt),
		.eq        (eq),
		.values    (values),
		.pos       (pos),
		.hit       (hit),
		.hit_value (hit_value)
	);

	always_comb begin
		rsp_d.position    = POS_W'(pos);
		rsp_d.found_value = '0;
		if (req_s2.operation == OP_INSERT) begin
			if (full) begin
				rsp_d.status   = ST_FULL;
				rsp_d.position = '0;
			end else if (hit) begin
				rsp_d.status = ST_DUP;
			end else begin
				rsp_d.status = ST_OK;
			end
		end else begin
			if (hit) begin
				rsp_d.status      = ST_OK;
				rsp_d.found_value = hit_value;
			end else begin
				rsp_d.status = ST_MISS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (commit) begin
				v_s2 <= 1'b0;
			end
			if (ins_en) begin
				count_q <= count_q + 1'b1;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (v_s1) begin
			req_s2 <= req_s1;
		end
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above capacity");

	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0(eq))
		else $error("key stored in more than one cell");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> count_q == $past(count_q) + 1'b1)
		else $error("entry count did not advance on insert");

	a_s1_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2 && !v_s1)
		else $error("compare stage did not advance");

endmodule

// ===== tb/sv/sorted_id_map_insert_lookup_tb.sv =====
`timescale 1ns / 1ps

module sorted_id_map_insert_lookup_tb;
	import sim_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RAND_ITEMS  = 850;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t rs;
	} dir_row_t;

	logic  clk;
	logic  arst_n;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	logic [KEY_W-1:0] map_keys [DEPTH];
	logic [VAL_W-1:0] map_vals [DEPTH];
	int               map_count;
	rsp_t             map_pending [$];

	int unsigned cycle_count = 0;
	int          mismatch_count = 0;
	int          rsp_hold = 0;
	bit          req_quiet = 1'b0;
	bit          rsp_quiet = 1'b0;

	dir_row_t dir_rows [18] = '{
		'{'{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{ST_MISS, 6'd0, 32'h0}},
		'{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{ST_MISS, 6'd0, 32'h0}},
		'{'{OP_INSERT, 32'h8000_0000, 32'h1234_5678}, 1'b1, '{ST_OK, 6'd0, 32'h0}},
		'{'{OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{ST_OK, 6'd0, 32'h0}},
		'{'{OP_INSERT, 32'hFFFF_FFFE, 32'h0000_0000}, 1'b1, '{ST_OK, 6'd2, 32'h0}},
		'{'{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{ST_OK, 6'd0, 32'hFFFF_FFFF}},
		'{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{ST_MISS, 6'd3, 32'h0}},
		'{'{OP_INSERT, 32'h8000_0000, 32'hAAAA_AAAA}, 1'b1, '{ST_DUP, 6'd1, 32'h0}},
		'{'{OP_INSERT, 32'h7FFF_FFFF, 32'h5555_5555}, 1'b0, '0},
		'{'{OP_INSERT, 32'h8000_0001, 32'h0F0F_0F0F}, 1'b0, '0},
		'{'{OP_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b0, '0},
		'{'{OP_LOOKUP, 32'h7FFF_FFFE, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_INSERT, 32'hFFFF_FFFD, 32'h0000_0001}, 1'b0, '0},
		'{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_INSERT, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{ST_DUP, 6'd0, 32'h0}},
		'{'{OP_INSERT, 32'h0000_0001, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_LOOKUP, 32'h0000_0001, 32'hF0F0_F0F0}, 1'b0, '0}
	};

	sorted_id_map_insert_lookup u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("sorted_id_map_insert_lookup_tb: FAIL");
		$finish;
	end

	function automatic rsp_t map_apply(req_t r);
		rsp_t o = '0;
		int   p = 0;
		int   i;
		bit   hit;
		while (p < map_count && map_keys[p] < r.global_key)
			p++;
		hit = (p < map_count) && (map_keys[p] == r.global_key);
		if (r.operation == OP_INSERT) begin
			if (map_count >= DEPTH) begin
				o.status = ST_FULL;
			end else if (hit) begin
				o.status = ST_DUP;
				o.position = p[POS_W-1:0];
			end else begin
				for (i = map_count; i > p; i--) begin
					map_keys[i] = map_keys[i-1];
					map_vals[i] = map_vals[i-1];
				end
				map_keys[p] = r.global_key;
				map_vals[p] = r.local_value;
				map_count++;
				o.status = ST_OK;
				o.position = p[POS_W-1:0];
			end
		end else if (hit) begin
			o.status = ST_OK;
			o.position = p[POS_W-1:0];
			o.found_value = map_vals[p];
		end else begin
			o.status = ST_MISS;
			o.position = p[POS_W-1:0];
		end
		return o;
	endfunction

	function automatic int idle_cycles(bit quiet);
		return quiet ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		int               r;
		r = $urandom_range(0, 15);
		if (r < 2) begin
			case ($urandom_range(0, 5))
				0: k = 32'h0000_0000;
				1: k = 32'h0000_0001;
				2: k = 32'h7FFF_FFFF;
				3: k = 32'h8000_0000;
				4: k = 32'hFFFF_FFFE;
				default: k = 32'hFFFF_FFFF;
			endcase
		end else if (r < 6) begin
			k = $urandom_range(0, 255);
		end else if (r < 8 && map_count > 0) begin
			k = map_keys[$urandom_range(0, map_count - 1)];
			k = $urandom_range(0, 1) ? k + 1 : k - 1;
		end else begin
			k = $urandom;
		end
		return k;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR: %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_request(req_t r, bit typed, rsp_t fixed, bit drain);
		int gap;
		rsp_t pred;
		if ($urandom_range(0, 39) == 0)
			req_quiet = !req_quiet;
		gap = idle_cycles(req_quiet);
		if (gap > 0 || drain) begin
			req_valid <= 1'b0;
			repeat ((gap > 0) ? gap : 1) @(posedge clk);
			while (map_pending.size() != 0) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pred = map_apply(r);
		map_pending.push_back(typed ? fixed : pred);
	endtask

	always @(posedge clk) begin
		rsp_t exp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (map_pending.size() == 0) begin
				report_mismatch($sformatf("response with none pending: %p", rsp));
			end else begin
				exp = map_pending.pop_front();
				if (rsp.status !== exp.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp.status, exp.status));
				if (rsp.position !== exp.position)
					report_mismatch($sformatf("position got %0d want %0d",
						rsp.position, exp.position));
				if (rsp.found_value !== exp.found_value)
					report_mismatch($sformatf("found_value got %h want %h",
						rsp.found_value, exp.found_value));
			end
			if ($urandom_range(0, 39) == 0)
				rsp_quiet = !rsp_quiet;
			rsp_hold = idle_cycles(rsp_quiet);
		end else if (rsp_valid && rsp_hold > 0) begin
			rsp_hold--;
		end
		rsp_stall <= (rsp_hold > 0);
	end

	initial begin
		req_t r;
		int   i;
		bit   drain;
		bit   was_full;
		map_count = 0;
		was_full = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (dir_rows[j])
			send_request(dir_rows[j].rq, dir_rows[j].typed, dir_rows[j].rs, 1'b0);
		for (i = 0; i < RAND_ITEMS; i++) begin
			r.local_value = $urandom;
			if (map_count < DEPTH && (RAND_ITEMS - i <= 300 || $urandom_range(0, 99) < 40))
				r.operation = OP_INSERT;
			else if (map_count >= DEPTH && $urandom_range(0, 99) < 30)
				r.operation = OP_INSERT;
			else
				r.operation = OP_LOOKUP;
			if (map_count > 0 && r.operation == OP_INSERT && $urandom_range(0, 99) < 30) begin
				r.global_key = map_keys[$urandom_range(0, map_count - 1)];
			end else if (map_count > 0 && r.operation == OP_LOOKUP
					&& $urandom_range(0, 99) < 55) begin
				r.global_key = map_keys[$urandom_range(0, map_count - 1)];
			end else begin
				r.global_key = pick_key();
				// keep the top key free so a miss past the last entry stays reachable
				if (r.operation == OP_INSERT && r.global_key == 32'hFFFF_FFFF)
					r.global_key = $urandom_range(0, 255);
			end
			drain = (i == 0) || (i % 200 == 100) || (map_count >= DEPTH && !was_full);
			was_full = (map_count >= DEPTH);
			send_request(r, 1'b0, '0, drain);
		end
		req_valid <= 1'b0;
		while (map_pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && map_pending.size() == 0)
			$display("sorted_id_map_insert_lookup_tb: PASS");
		else
			$display("sorted_id_map_insert_lookup_tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sim_pkg.sv
rtl/sim_cell.sv
rtl/sim_sel.sv
rtl/sorted_id_map_insert_lookup.sv
tb/sv/sorted_id_map_insert_lookup_tb.sv
